### hdl/fsba_pkg.sv
// Shared types and constants of the fixed-size block allocator.
// Holds the request and response structs, status codes and register map.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fsba_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W   = 48;
    localparam int BYTES_W  = 40;
    localparam int SIZE_W   = 15;
    localparam int CHUNKS_W = 16;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 64;
    localparam int PADDR_W  = 5;

    // Default sizing of the allocator.
    localparam int DEF_CHUNK_BYTES = 16384;
    localparam int DEF_FREE_DEPTH  = 256;
    localparam int DEF_MIN_OBJECT  = 8;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNINIT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Register indexes; each register sits on an 8-byte boundary.
    localparam logic [1:0] REG_OBJECT_SIZE   = 2'd0;
    localparam logic [1:0] REG_ZERO_ON_REUSE = 2'd1;
    localparam logic [1:0] REG_ARENA_BASE    = 2'd2;
    localparam logic [1:0] REG_ARENA_CHUNKS  = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] free_addr;
    } fsba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   obj_addr;
        logic [STATUS_W-1:0] status;
        logic                needs_clear;
        logic [BYTES_W-1:0]  bytes_in_use;
    } fsba_rsp_t;

    // Shift commands sent to every cell of the free-address stack.
    typedef struct packed {
        logic push;
        logic pop;
    } fsba_stk_ctrl_t;

endpackage

`default_nettype wire

### hdl/fsba_cell.sv
// One cell of the free-address stack: holds a single address.
// On a push it takes the entry above it, on a pop the entry below it.
// Depends on fsba_pkg.
`default_nettype none

module fsba_cell (
    input  wire logic                   clk,
    input  wire fsba_pkg::fsba_stk_ctrl_t ctrl,
    input  wire logic [fsba_pkg::ADDR_W-1:0] up_data,
    input  wire logic [fsba_pkg::ADDR_W-1:0] down_data,
    output logic [fsba_pkg::ADDR_W-1:0]      q
);
    import fsba_pkg::*;

    logic [ADDR_W-1:0] data_reg;
    logic [ADDR_W-1:0] data_next;

    // Select the neighbor that moves into this cell.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = up_data;
        end
        else if (ctrl.pop)
        begin
            data_next = down_data;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

### hdl/fsba_stack.sv
// LIFO free-address store built as a row of shifting cells.
// The newest entry always sits in cell 0, so the top is read without a memory.
// Depends on fsba_pkg and fsba_cell.
`default_nettype none

module fsba_stack #(
    parameter int DEPTH = fsba_pkg::DEF_FREE_DEPTH
) (
    input  wire logic                        clk,
    input  wire fsba_pkg::fsba_stk_ctrl_t    ctrl,
    input  wire logic [fsba_pkg::ADDR_W-1:0] push_data,
    output logic [fsba_pkg::ADDR_W-1:0]      top
);
    import fsba_pkg::*;

    logic [ADDR_W-1:0] cell_q [DEPTH];

    // Each cell links to its two neighbors; the ends see the new entry and themselves.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ADDR_W-1:0] up_w;
        logic [ADDR_W-1:0] down_w;

        if (i == 0)
        begin : g_first
            assign up_w = push_data;
        end
        else
        begin : g_mid_up
            assign up_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign down_w = cell_q[i];
        end
        else
        begin : g_mid_down
            assign down_w = cell_q[i+1];
        end

        fsba_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .up_data   (up_w),
            .down_data (down_w),
            .q         (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule

`default_nettype wire

### hdl/fixed_size_block_allocator_unit.sv
// Top level of the fixed-size block allocator: request decode, bump allocator,
// byte accounting and the configuration register file.
// Depends on fsba_pkg and fsba_stack.
//
// Usage:
//   A request (allocate or free) is transferred at a rising edge where start is
//   high and busy is low. Exactly one response follows: done is high for one
//   cycle, the cycle right after the request, with rsp valid in that cycle.
//   A new request can be issued each cycle while busy is low; this rate comes
//   from the free-address stack keeping its top entry in cell 0 and the chunk
//   bookkeeping being one add and compare.
//   The receiver cannot stall; a response is gone after its one cycle.
//   busy is high only while the configuration port is selected.
//   Configuration uses the APB-style port; registers sit at byte addresses
//   0x00 object_size, 0x08 zero_on_reuse, 0x10 arena_base, 0x18 arena_chunks.
//   Writing object_size empties the free store and drops the current chunk
//   and the byte count; chunks already taken from the arena stay taken.
//   After reset object_size is zero, so every request answers not initialized
//   until software writes a size. No clearing pass is needed after reset.
`default_nettype none

module fixed_size_block_allocator_unit #(
    parameter int CHUNK_BYTES = fsba_pkg::DEF_CHUNK_BYTES,
    parameter int FREE_DEPTH  = fsba_pkg::DEF_FREE_DEPTH,
    parameter int MIN_OBJECT  = fsba_pkg::DEF_MIN_OBJECT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Request channel.
    input  wire logic                         start,
    output logic                              busy,
    input  wire fsba_pkg::fsba_req_t          req,
    // Response channel.
    output logic                              done,
    output fsba_pkg::fsba_rsp_t               rsp,
    // Configuration port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fsba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [fsba_pkg::DATA_W-1:0]  pwdata,
    output logic [fsba_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import fsba_pkg::*;

    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int USED_W = $clog2(CHUNK_BYTES + 1);

    // Configuration registers.
    logic [SIZE_W-1:0]   obj_size_reg;
    logic                zero_reuse_reg;
    logic [ADDR_W-1:0]   arena_base_reg;
    logic [CHUNKS_W-1:0] arena_chunks_reg;

    // Allocator state.
    logic [CNT_W-1:0]    free_count_reg,   free_count_next;
    logic [ADDR_W-1:0]   bump_reg,         bump_next;
    logic [USED_W-1:0]   used_reg,         used_next;
    logic                chunk_valid_reg,  chunk_valid_next;
    logic [CHUNKS_W-1:0] chunks_taken_reg, chunks_taken_next;
    logic [ADDR_W-1:0]   chunk_ofs_reg,    chunk_ofs_next;
    logic [BYTES_W-1:0]  in_use_reg,       in_use_next;

    // Response register.
    logic      done_reg;
    fsba_rsp_t rsp_reg, rsp_next;

    logic              cfg_wr;
    logic              accept;
    logic [SIZE_W-1:0] size_eff;
    logic              size_ok;
    logic              need_chunk;
    logic [ADDR_W-1:0] fresh_addr;
    logic [BYTES_W:0]  in_use_sum;
    logic [ADDR_W-1:0] stack_top;
    fsba_stk_ctrl_t    stk_ctrl;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = psel;
    assign accept = start && !busy;

    // Register file writes; only done while no request is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_size_reg     <= '0;
            zero_reuse_reg   <= 1'b1;
            arena_base_reg   <= '0;
            arena_chunks_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_OBJECT_SIZE:   obj_size_reg     <= pwdata[SIZE_W-1:0];
                REG_ZERO_ON_REUSE: zero_reuse_reg   <= pwdata[0];
                REG_ARENA_BASE:    arena_base_reg   <= pwdata[ADDR_W-1:0];
                REG_ARENA_CHUNKS:  arena_chunks_reg <= pwdata[CHUNKS_W-1:0];
                default:           obj_size_reg     <= obj_size_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:3])
            REG_OBJECT_SIZE:   prdata = DATA_W'(obj_size_reg);
            REG_ZERO_ON_REUSE: prdata = DATA_W'(zero_reuse_reg);
            REG_ARENA_BASE:    prdata = DATA_W'(arena_base_reg);
            REG_ARENA_CHUNKS:  prdata = DATA_W'(arena_chunks_reg);
            default:           prdata = '0;
        endcase
    end

    // Effective object size: sizes below MIN_OBJECT round up to it; zero or above one chunk is unusable.
    always_comb
    begin
        size_ok  = (obj_size_reg != '0) && (32'(obj_size_reg) <= 32'(CHUNK_BYTES));
        size_eff = obj_size_reg;
        if (32'(obj_size_reg) < 32'(MIN_OBJECT))
        begin
            size_eff = SIZE_W'(MIN_OBJECT);
        end
    end

    // A new chunk is needed when none is open or the next object would not fit.
    assign need_chunk = !chunk_valid_reg
                        || (32'(used_reg) + 32'(size_eff) > 32'(CHUNK_BYTES));
    assign fresh_addr = need_chunk ? (arena_base_reg + chunk_ofs_reg) : bump_reg;
    assign in_use_sum = {1'b0, in_use_reg} + (BYTES_W + 1)'(size_eff);

    // Request decode and next-state logic.
    always_comb
    begin
        free_count_next   = free_count_reg;
        bump_next         = bump_reg;
        used_next         = used_reg;
        chunk_valid_next  = chunk_valid_reg;
        chunks_taken_next = chunks_taken_reg;
        chunk_ofs_next    = chunk_ofs_reg;
        in_use_next       = in_use_reg;
        stk_ctrl          = '0;
        rsp_next          = rsp_reg;

        if (cfg_wr && (paddr[4:3] == REG_OBJECT_SIZE))
        begin
            free_count_next  = '0;
            bump_next        = '0;
            used_next        = '0;
            chunk_valid_next = 1'b0;
            in_use_next      = '0;
        end
        else if (accept)
        begin
            rsp_next.obj_addr    = '0;
            rsp_next.needs_clear = 1'b0;
            if (!size_ok)
            begin
                rsp_next.status = ST_UNINIT;
            end
            else if (req.kind == KIND_ALLOC)
            begin
                if (free_count_reg != '0)
                begin
                    // Reuse the most recently freed address.
                    stk_ctrl.pop         = 1'b1;
                    free_count_next      = free_count_reg - 1'b1;
                    rsp_next.obj_addr    = stack_top;
                    rsp_next.needs_clear = zero_reuse_reg;
                    rsp_next.status      = ST_REUSED;
                    in_use_next = in_use_sum[BYTES_W] ? '1 : in_use_sum[BYTES_W-1:0];
                end
                else if (need_chunk && (chunks_taken_reg >= arena_chunks_reg))
                begin
                    rsp_next.status = ST_EXHAUSTED;
                end
                else
                begin
                    // Bump allocation, opening the next arena chunk when needed.
                    if (need_chunk)
                    begin
                        chunk_valid_next  = 1'b1;
                        chunks_taken_next = chunks_taken_reg + 1'b1;
                        chunk_ofs_next    = chunk_ofs_reg + ADDR_W'(CHUNK_BYTES);
                        used_next         = USED_W'(size_eff);
                    end
                    else
                    begin
                        used_next = used_reg + USED_W'(size_eff);
                    end
                    bump_next         = fresh_addr + ADDR_W'(size_eff);
                    rsp_next.obj_addr = fresh_addr;
                    rsp_next.status   = ST_FRESH;
                    in_use_next = in_use_sum[BYTES_W] ? '1 : in_use_sum[BYTES_W-1:0];
                end
            end
            else
            begin
                if (free_count_reg == CNT_W'(FREE_DEPTH))
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    stk_ctrl.push   = 1'b1;
                    free_count_next = free_count_reg + 1'b1;
                    rsp_next.status = ST_FREED;
                    in_use_next = (in_use_reg >= BYTES_W'(size_eff))
                                  ? (in_use_reg - BYTES_W'(size_eff)) : '0;
                end
            end
            rsp_next.bytes_in_use = in_use_next;
        end
    end

    // Control and counter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg   <= '0;
            bump_reg         <= '0;
            used_reg         <= '0;
            chunk_valid_reg  <= 1'b0;
            chunks_taken_reg <= '0;
            chunk_ofs_reg    <= '0;
            in_use_reg       <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            free_count_reg   <= free_count_next;
            bump_reg         <= bump_next;
            used_reg         <= used_next;
            chunk_valid_reg  <= chunk_valid_next;
            chunks_taken_reg <= chunks_taken_next;
            chunk_ofs_reg    <= chunk_ofs_next;
            in_use_reg       <= in_use_next;
            done_reg         <= accept;
        end
    end

    // Response payload holds no control state.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    fsba_stack #(
        .DEPTH (FREE_DEPTH)
    ) u_stack (
        .clk       (clk),
        .ctrl      (stk_ctrl),
        .push_data (req.free_addr),
        .top       (stack_top)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Each transferred request yields exactly one response in the next cycle.
    a_one_response: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request transfer without a response");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("response without a request transfer");

    // The free count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_count_reg) <= 32'(FREE_DEPTH))
        else $error("free count beyond store depth");

    // An open chunk never holds more bytes than a chunk has.
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(CHUNK_BYTES))
        else $error("chunk usage beyond chunk size");

    // Only a successful allocate hands out an address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_REUSED) && (rsp.status != ST_FRESH))
        |-> (rsp.obj_addr == '0) && !rsp.needs_clear)
        else $error("address reported on a failed or free request");

endmodule

`default_nettype wire
